// ===== src/rsa_pkg.sv =====
// Package for the rational sum accumulator: widths, status codes and sequencer states.
// Depends on nothing; used by rational_sum_accumulator_top.
package rsa_pkg;

  localparam int unsigned DefValueWidth = 32;
  localparam int unsigned InWidth       = 32;
  localparam int unsigned ProdWidth     = 64;
  localparam int unsigned CntWidth      = 7;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_DEN = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_D,
    ST_COMBINE,
    ST_GCD_START,
    ST_GCD_DIV,
    ST_GCD_STEP,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_CHECK,
    ST_OUT
  } state_e;

endpackage

// ===== src/rational_sum_accumulator_top.sv =====
// Rational sum accumulator: adds one signed fraction per beat to a running sum and reduces it.
// Depends on rsa_pkg; one shared 64-bit restoring divider and one 32x32 multiplier.
//
// Channel | Direction | Signals
// in      | to block  | in_valid_i, in_stall_o, frac_numerator_i, frac_denominator_i, restart_i
// out     | from block| out_valid_o, out_stall_i, sum_numerator_o, sum_denominator_o, status_o
//
// One beat runs one division per Euclid remainder step and one for each of the two divisions
// by the GCD, plus set-up and control states; a zero denominator is answered at once.
// The bit-serial divider, one quotient bit per cycle, takes most of a beat's time.
// Reset clears the sum to 0/1 and the sequencer to idle.
// The input is stalled while a beat is being worked on or its result waits to be taken.
module rational_sum_accumulator_top #(
  parameter int unsigned VALUE_WIDTH = rsa_pkg::DefValueWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [rsa_pkg::InWidth-1:0] frac_numerator_i,
  input  logic signed [rsa_pkg::InWidth-1:0] frac_denominator_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [rsa_pkg::InWidth-1:0] sum_numerator_o,
  output logic [rsa_pkg::InWidth-2:0]        sum_denominator_o,
  output logic [1:0]  status_o
);
  import rsa_pkg::*;

  localparam logic [ProdWidth-1:0] LimitMag = ProdWidth'(1) << (VALUE_WIDTH - 1);

  state_e state_q, state_d;
  logic signed [InWidth-1:0] acc_num_q, acc_num_d;
  logic [InWidth-1:0] acc_den_q, acc_den_d;
  logic nneg_q, nneg_d, dneg_q, dneg_d, rneg_q, rneg_d;
  logic [InWidth-1:0] nmag_q, nmag_d, dmag_q, dmag_d;
  logic [ProdWidth-1:0] amag_q, amag_d, bmag_q, bmag_d, rmag_q, rmag_d, rden_q, rden_d;
  logic [ProdWidth-1:0] x_q, x_d, y_q, y_d;
  logic [ProdWidth-1:0] quo_q, quo_d, rem_q, rem_d, dvd_q, dvd_d, dvs_q, dvs_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic div_run_q, div_run_d;
  logic [1:0] status_q, status_d;
  logic out_valid_q, out_valid_d;

  logic [InWidth-1:0] mul_a, mul_b;
  logic [ProdWidth-1:0] mul_p;
  logic [ProdWidth:0] rem_sh;
  logic [ProdWidth:0] rem_sub;
  logic aneg;
  logic [InWidth-1:0] amag32;

  assign mul_p = ProdWidth'(mul_a) * ProdWidth'(mul_b);
  assign rem_sh = {rem_q, dvd_q[ProdWidth-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign aneg = acc_num_q[InWidth-1];
  assign amag32 = aneg ? (~acc_num_q + 1'b1) : acc_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_num_q <= '0;
      acc_den_q <= InWidth'(1);
      out_valid_q <= 1'b0;
      div_run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      acc_num_q <= acc_num_d;
      acc_den_q <= acc_den_d;
      out_valid_q <= out_valid_d;
      div_run_q <= div_run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nneg_q <= nneg_d; dneg_q <= dneg_d; rneg_q <= rneg_d;
    nmag_q <= nmag_d; dmag_q <= dmag_d;
    amag_q <= amag_d; bmag_q <= bmag_d; rmag_q <= rmag_d; rden_q <= rden_d;
    x_q <= x_d; y_q <= y_d;
    quo_q <= quo_d; rem_q <= rem_d; dvd_q <= dvd_d; dvs_q <= dvs_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d = state_q;
    acc_num_d = acc_num_q; acc_den_d = acc_den_q;
    nneg_d = nneg_q; dneg_d = dneg_q; rneg_d = rneg_q;
    nmag_d = nmag_q; dmag_d = dmag_q;
    amag_d = amag_q; bmag_d = bmag_q; rmag_d = rmag_q; rden_d = rden_q;
    x_d = x_q; y_d = y_q;
    quo_d = quo_q; rem_d = rem_q; dvd_d = dvd_q; dvs_d = dvs_q;
    cnt_d = cnt_q; div_run_d = div_run_q;
    status_d = status_q;
    out_valid_d = out_valid_q;
    mul_a = '0; mul_b = '0;

    if (div_run_q) begin
      if (rem_sub[ProdWidth]) begin
        rem_d = rem_sh[ProdWidth-1:0];
        quo_d = {quo_q[ProdWidth-2:0], 1'b0};
      end else begin
        rem_d = rem_sub[ProdWidth-1:0];
        quo_d = {quo_q[ProdWidth-2:0], 1'b1};
      end
      dvd_d = {dvd_q[ProdWidth-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) div_run_d = 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (restart_i) begin
              acc_num_d = '0;
              acc_den_d = InWidth'(1);
            end
            nneg_d = frac_numerator_i[InWidth-1];
            dneg_d = frac_denominator_i[InWidth-1];
            nmag_d = nneg_d ? (~frac_numerator_i + 1'b1) : frac_numerator_i;
            dmag_d = dneg_d ? (~frac_denominator_i + 1'b1) : frac_denominator_i;
            if (frac_denominator_i == '0) begin
              status_d = STATUS_ZERO_DEN;
              state_d = ST_OUT;
              out_valid_d = 1'b1;
            end else begin
              state_d = ST_MUL_A;
            end
          end
        end
        ST_MUL_A: begin
          mul_a = amag32; mul_b = dmag_q;
          amag_d = mul_p;
          state_d = ST_MUL_B;
        end
        ST_MUL_B: begin
          mul_a = nmag_q; mul_b = acc_den_q;
          bmag_d = mul_p;
          state_d = ST_MUL_D;
        end
        ST_MUL_D: begin
          mul_a = acc_den_q; mul_b = dmag_q;
          rden_d = mul_p;
          state_d = ST_COMBINE;
        end
        ST_COMBINE: begin
          if (aneg == (nneg_q != dneg_q)) begin
            rneg_d = aneg; rmag_d = amag_q + bmag_q;
          end else if (amag_q >= bmag_q) begin
            rneg_d = aneg; rmag_d = amag_q - bmag_q;
          end else begin
            rneg_d = ~aneg; rmag_d = bmag_q - amag_q;
          end
          state_d = ST_GCD_START;
        end
        ST_GCD_START: begin
          if (rmag_q == '0) begin
            rneg_d = 1'b0;
            rden_d = ProdWidth'(1);
            state_d = ST_CHECK;
          end else begin
            x_d = rmag_q; y_d = rden_q;
            state_d = ST_GCD_DIV;
          end
        end
        ST_GCD_DIV: begin
          if (y_q == '0) begin
            dvd_d = rmag_q; dvs_d = x_q; rem_d = '0; quo_d = '0;
            cnt_d = CntWidth'(ProdWidth); div_run_d = 1'b1;
            state_d = ST_DIV_NUM;
          end else begin
            dvd_d = x_q; dvs_d = y_q; rem_d = '0; quo_d = '0;
            cnt_d = CntWidth'(ProdWidth); div_run_d = 1'b1;
            state_d = ST_GCD_STEP;
          end
        end
        ST_GCD_STEP: begin
          x_d = y_q; y_d = rem_q;
          state_d = ST_GCD_DIV;
        end
        ST_DIV_NUM: begin
          rmag_d = quo_q;
          dvd_d = rden_q; dvs_d = x_q; rem_d = '0; quo_d = '0;
          cnt_d = CntWidth'(ProdWidth); div_run_d = 1'b1;
          state_d = ST_DIV_DEN;
        end
        ST_DIV_DEN: begin
          rden_d = quo_q;
          state_d = ST_CHECK;
        end
        ST_CHECK: begin
          if (rden_q >= LimitMag || (rneg_q ? rmag_q > LimitMag : rmag_q >= LimitMag)) begin
            status_d = STATUS_OVERFLOW;
          end else begin
            status_d = STATUS_OK;
            acc_num_d = rneg_q ? (~rmag_q[InWidth-1:0] + 1'b1) : rmag_q[InWidth-1:0];
            acc_den_d = rden_q[InWidth-1:0];
          end
          out_valid_d = 1'b1;
          state_d = ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            out_valid_d = 1'b0;
            state_d = ST_IDLE;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign sum_numerator_o = acc_num_q;
  assign sum_denominator_o = acc_den_q[InWidth-2:0];
  assign status_o = status_q;

endmodule
